// ----- sv/gate_mains_cycle_supervisor_assert.svh -----
// assertion macros used by the gate mains cycle supervisor top level
`ifndef GATE_MAINS_CYCLE_SUPERVISOR_ASSERT_SVH
`define GATE_MAINS_CYCLE_SUPERVISOR_ASSERT_SVH

// condition implies consequence in the same cycle, sampled on aclk
`define GMCS_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error("gmcs assertion failed");

// condition implies consequence in the next cycle, sampled on aclk
`define GMCS_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error("gmcs assertion failed");

`endif

// ----- sv/gmcs_pkg.sv -----
// shared types and constants of the gate mains cycle supervisor
`default_nettype none
package gmcs_pkg;

    localparam int unsigned CfgAddrWidth = 5;

    typedef enum logic [2:0] {
        REG_MORNING_HOUR       = 3'd0,
        REG_MORNING_MINUTE     = 3'd1,
        REG_NIGHT_HOUR         = 3'd2,
        REG_NIGHT_MINUTE       = 3'd3,
        REG_BATTERY_THRESHOLD  = 3'd4,
        REG_BATTERY_HYSTERESIS = 3'd5,
        REG_FORCE_CYCLE_LIMIT  = 3'd6
    } reg_index_t;

    localparam logic [4:0]  MORNING_HOUR_RST       = 5'd7;
    localparam logic [5:0]  MORNING_MINUTE_RST     = 6'd0;
    localparam logic [4:0]  NIGHT_HOUR_RST         = 5'd20;
    localparam logic [5:0]  NIGHT_MINUTE_RST       = 6'd0;
    localparam logic [11:0] BATTERY_THRESHOLD_RST  = 12'd2048;
    localparam logic [11:0] BATTERY_HYSTERESIS_RST = 12'd100;
    localparam logic [15:0] FORCE_CYCLE_LIMIT_RST  = 16'd10;

    localparam logic [15:0] UNPOWERED_MAX = 16'hFFFF;

    typedef struct packed {
        logic [4:0]  morning_hour;
        logic [5:0]  morning_minute;
        logic [4:0]  night_hour;
        logic [5:0]  night_minute;
        logic [11:0] battery_threshold;
        logic [11:0] battery_hysteresis;
        logic [15:0] force_cycle_limit;
    } cfg_t;

    typedef struct packed {
        logic [4:0]  day_of_month;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic        cycle_active;
        logic        mains_present;
        logic [11:0] battery_level;
    } sample_t;

    typedef struct packed {
        logic        force_open;
        logic        open_pulse;
        logic        outage_started;
        logic        force_started;
        logic        day_cycle_counted;
        logic        night_cycle_counted;
        logic [15:0] today_day_cycles;
        logic [15:0] today_night_cycles;
        logic [31:0] total_day_cycles;
        logic [31:0] total_night_cycles;
        logic [31:0] outage_total;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/gmcs_cfg_regs.sv -----
// apb configuration registers of the gate mains cycle supervisor
`default_nettype none
module gmcs_cfg_regs
    import gmcs_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [CfgAddrWidth-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    output cfg_t                         cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[CfgAddrWidth-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.morning_hour       <= MORNING_HOUR_RST;
            cfg_reg.morning_minute     <= MORNING_MINUTE_RST;
            cfg_reg.night_hour         <= NIGHT_HOUR_RST;
            cfg_reg.night_minute       <= NIGHT_MINUTE_RST;
            cfg_reg.battery_threshold  <= BATTERY_THRESHOLD_RST;
            cfg_reg.battery_hysteresis <= BATTERY_HYSTERESIS_RST;
            cfg_reg.force_cycle_limit  <= FORCE_CYCLE_LIMIT_RST;
        end else if (wr_en) begin
            unique case (index)
                REG_MORNING_HOUR:       cfg_reg.morning_hour       <= pwdata[4:0];
                REG_MORNING_MINUTE:     cfg_reg.morning_minute     <= pwdata[5:0];
                REG_NIGHT_HOUR:         cfg_reg.night_hour         <= pwdata[4:0];
                REG_NIGHT_MINUTE:       cfg_reg.night_minute       <= pwdata[5:0];
                REG_BATTERY_THRESHOLD:  cfg_reg.battery_threshold  <= pwdata[11:0];
                REG_BATTERY_HYSTERESIS: cfg_reg.battery_hysteresis <= pwdata[11:0];
                REG_FORCE_CYCLE_LIMIT:  cfg_reg.force_cycle_limit  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_MORNING_HOUR:       prdata = {27'd0, cfg_reg.morning_hour};
            REG_MORNING_MINUTE:     prdata = {26'd0, cfg_reg.morning_minute};
            REG_NIGHT_HOUR:         prdata = {27'd0, cfg_reg.night_hour};
            REG_NIGHT_MINUTE:       prdata = {26'd0, cfg_reg.night_minute};
            REG_BATTERY_THRESHOLD:  prdata = {20'd0, cfg_reg.battery_threshold};
            REG_BATTERY_HYSTERESIS: prdata = {20'd0, cfg_reg.battery_hysteresis};
            REG_FORCE_CYCLE_LIMIT:  prdata = {16'd0, cfg_reg.force_cycle_limit};
            default:                prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/gmcs_update.sv -----
// supervisor state registers and per-sample update logic
`default_nettype none
module gmcs_update
    import gmcs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    step,
    input  wire cfg_t    cfg,
    input  wire sample_t sample,
    output result_t      result
);

    logic [4:0]  last_day_reg,      last_day_next;
    logic        cycle_armed_reg,   cycle_armed_next;
    logic        mains_armed_reg,   mains_armed_next;
    logic        force_noted_reg,   force_noted_next;
    logic        force_flag_reg,    force_flag_next;
    logic [15:0] day_today_reg,     day_today_next;
    logic [15:0] night_today_reg,   night_today_next;
    logic [31:0] day_total_reg,     day_total_next;
    logic [31:0] night_total_reg,   night_total_next;
    logic [31:0] outage_reg,        outage_next;
    logic [15:0] unpowered_reg,     unpowered_next;

    logic        day_change;
    logic        count_cycle;
    logic        after_morning;
    logic        before_night;
    logic        daytime;
    logic [15:0] day_today_base;
    logic [15:0] night_today_base;
    logic [15:0] unpowered_mid;
    logic        mains_loss;
    logic        mains_out;
    logic        mains_back;
    logic [12:0] release_level;

    always_comb begin
        day_change       = sample.day_of_month != last_day_reg;
        last_day_next    = sample.day_of_month;
        day_today_base   = day_change ? 16'd0 : day_today_reg;
        night_today_base = day_change ? 16'd0 : night_today_reg;

        after_morning = (sample.hour_now > cfg.morning_hour) ||
                        (sample.hour_now == cfg.morning_hour &&
                         sample.minute_now >= cfg.morning_minute);
        before_night  = (sample.hour_now < cfg.night_hour) ||
                        (sample.hour_now == cfg.night_hour &&
                         sample.minute_now < cfg.night_minute);
        daytime       = after_morning && before_night;

        // rising edge of the cycle flag counts once, re-armed when it drops
        count_cycle      = sample.cycle_active && cycle_armed_reg;
        cycle_armed_next = !sample.cycle_active;

        day_today_next   = day_today_base;
        night_today_next = night_today_base;
        day_total_next   = day_total_reg;
        night_total_next = night_total_reg;
        unpowered_mid    = unpowered_reg;
        if (count_cycle) begin
            if (daytime) begin
                day_today_next = day_today_base + 16'd1;
                day_total_next = day_total_reg + 32'd1;
            end else begin
                night_today_next = night_today_base + 16'd1;
                night_total_next = night_total_reg + 32'd1;
            end
            if (!sample.mains_present && unpowered_reg != UNPOWERED_MAX) begin
                unpowered_mid = unpowered_reg + 16'd1;
            end
        end

        mains_loss    = !sample.mains_present && mains_armed_reg;
        mains_out     = !sample.mains_present && !mains_armed_reg;
        mains_back    = sample.mains_present && !mains_armed_reg;
        release_level = {1'b0, cfg.battery_threshold} + {1'b0, cfg.battery_hysteresis};

        mains_armed_next = mains_armed_reg;
        outage_next      = outage_reg;
        force_flag_next  = force_flag_reg;
        unpowered_next   = unpowered_mid;
        if (mains_loss) begin
            mains_armed_next = 1'b0;
            outage_next      = outage_reg + 32'd1;
        end else if (mains_out) begin
            if (sample.battery_level < cfg.battery_threshold ||
                unpowered_mid >= cfg.force_cycle_limit) begin
                force_flag_next = 1'b1;
            end else if ({1'b0, sample.battery_level} > release_level) begin
                force_flag_next = 1'b0;
            end
        end else if (mains_back) begin
            unpowered_next   = 16'd0;
            force_flag_next  = 1'b0;
            mains_armed_next = 1'b1;
        end

        force_noted_next = force_flag_next;

        result.force_open          = force_flag_next;
        result.open_pulse          = mains_back;
        result.outage_started      = mains_loss;
        result.force_started       = force_flag_next && !force_noted_reg;
        result.day_cycle_counted   = count_cycle && daytime;
        result.night_cycle_counted = count_cycle && !daytime;
        result.today_day_cycles    = day_today_next;
        result.today_night_cycles  = night_today_next;
        result.total_day_cycles    = day_total_next;
        result.total_night_cycles  = night_total_next;
        result.outage_total        = outage_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_day_reg    <= 5'd0;
            cycle_armed_reg <= 1'b1;
            mains_armed_reg <= 1'b1;
            force_noted_reg <= 1'b0;
            force_flag_reg  <= 1'b0;
            day_today_reg   <= 16'd0;
            night_today_reg <= 16'd0;
            day_total_reg   <= 32'd0;
            night_total_reg <= 32'd0;
            outage_reg      <= 32'd0;
            unpowered_reg   <= 16'd0;
        end else if (step) begin
            last_day_reg    <= last_day_next;
            cycle_armed_reg <= cycle_armed_next;
            mains_armed_reg <= mains_armed_next;
            force_noted_reg <= force_noted_next;
            force_flag_reg  <= force_flag_next;
            day_today_reg   <= day_today_next;
            night_today_reg <= night_today_next;
            day_total_reg   <= day_total_next;
            night_total_reg <= night_total_next;
            outage_reg      <= outage_next;
            unpowered_reg   <= unpowered_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/gate_mains_cycle_supervisor.sv -----
// top level of the gate mains cycle supervisor: input register, update, result register
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_valid / s_ready  | one polled sample (clock, flags, battery)
//  m_       | out       | m_valid / m_ready  | one result per sample
//  apb      | in        | psel/penable/pready| seven configuration registers
//
// result valid once the sample has passed the input register, then the result register
// one sample per cycle is sustained while m_ready stays high; the single update stage
// between the input register and the result register sets that figure
// a stall on m_ready backs up into the input register, then drops s_ready
// aresetn is synchronous, active low; registers with a reset return to their reset
// values at once, no clearing pass
`default_nettype none
module gate_mains_cycle_supervisor
    import gmcs_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // apb configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [CfgAddrWidth-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    // sample channel
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [4:0]              s_day_of_month,
    input  wire logic [4:0]              s_hour_now,
    input  wire logic [5:0]              s_minute_now,
    input  wire logic                    s_cycle_active,
    input  wire logic                    s_mains_present,
    input  wire logic [11:0]             s_battery_level,
    // result channel
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_force_open,
    output logic                         m_open_pulse,
    output logic                         m_outage_started,
    output logic                         m_force_started,
    output logic                         m_day_cycle_counted,
    output logic                         m_night_cycle_counted,
    output logic      [15:0]             m_today_day_cycles,
    output logic      [15:0]             m_today_night_cycles,
    output logic      [31:0]             m_total_day_cycles,
    output logic      [31:0]             m_total_night_cycles,
    output logic      [31:0]             m_outage_total
);

`include "gate_mains_cycle_supervisor_assert.svh"

    cfg_t    cfg;
    sample_t sample_reg;
    logic    in_valid_reg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    step;

    // result register frees up when empty or being taken this cycle
    assign advance = !out_valid_reg || m_ready;
    // the held sample is applied to the state when it moves into the result register
    assign step    = in_valid_reg && advance;
    // input register can take a new sample when empty or emptying now
    assign s_ready = !in_valid_reg || advance;

    gmcs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gmcs_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .sample  (sample_reg),
        .result  (result)
    );

    // input register: control with reset, payload without
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg.day_of_month  <= s_day_of_month;
            sample_reg.hour_now      <= s_hour_now;
            sample_reg.minute_now    <= s_minute_now;
            sample_reg.cycle_active  <= s_cycle_active;
            sample_reg.mains_present <= s_mains_present;
            sample_reg.battery_level <= s_battery_level;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_force_open          = result_reg.force_open;
    assign m_open_pulse          = result_reg.open_pulse;
    assign m_outage_started      = result_reg.outage_started;
    assign m_force_started       = result_reg.force_started;
    assign m_day_cycle_counted   = result_reg.day_cycle_counted;
    assign m_night_cycle_counted = result_reg.night_cycle_counted;
    assign m_today_day_cycles    = result_reg.today_day_cycles;
    assign m_today_night_cycles  = result_reg.today_night_cycles;
    assign m_total_day_cycles    = result_reg.total_day_cycles;
    assign m_total_night_cycles  = result_reg.total_night_cycles;
    assign m_outage_total        = result_reg.outage_total;

    // a full pipe with a stalled consumer must refuse new samples
    `GMCS_ASSERT_SAME(a_full_stall_blocks, in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    // an accepted sample always lands in the input register
    `GMCS_ASSERT_NEXT(a_accept_loads, s_valid && s_ready, in_valid_reg)
    // a counted cycle is day or night, never both
    `GMCS_ASSERT_SAME(a_day_night_excl, m_valid, !(m_day_cycle_counted && m_night_cycle_counted))
    // mains return releases the force, and a new force shows as forced open
    `GMCS_ASSERT_SAME(a_force_flags, m_valid,
        !(m_open_pulse && m_force_open) && (!m_force_started || m_force_open))

endmodule
`default_nettype wire

// ----- tb/gate_mains_cycle_supervisor_test.sv -----
// self-checking testbench of the gate mains cycle supervisor with its own behavioral predictor
`default_nettype none
module gate_mains_cycle_supervisor_test
    import gmcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // register index that lies past the end of the register map, writes are dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // clock, reset and everything the testbench drives, known from time zero
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CfgAddrWidth-1:0] paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [4:0]              s_day_of_month = '0;
    logic [4:0]              s_hour_now = '0;
    logic [5:0]              s_minute_now = '0;
    logic                    s_cycle_active = 1'b0;
    logic                    s_mains_present = 1'b0;
    logic [11:0]             s_battery_level = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_force_open;
    logic                    m_open_pulse;
    logic                    m_outage_started;
    logic                    m_force_started;
    logic                    m_day_cycle_counted;
    logic                    m_night_cycle_counted;
    logic [15:0]             m_today_day_cycles;
    logic [15:0]             m_today_night_cycles;
    logic [31:0]             m_total_day_cycles;
    logic [31:0]             m_total_night_cycles;
    logic [31:0]             m_outage_total;

    gate_mains_cycle_supervisor dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_day_of_month       (s_day_of_month),
        .s_hour_now           (s_hour_now),
        .s_minute_now         (s_minute_now),
        .s_cycle_active       (s_cycle_active),
        .s_mains_present      (s_mains_present),
        .s_battery_level      (s_battery_level),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_force_open         (m_force_open),
        .m_open_pulse         (m_open_pulse),
        .m_outage_started     (m_outage_started),
        .m_force_started      (m_force_started),
        .m_day_cycle_counted  (m_day_cycle_counted),
        .m_night_cycle_counted(m_night_cycle_counted),
        .m_today_day_cycles   (m_today_day_cycles),
        .m_today_night_cycles (m_today_night_cycles),
        .m_total_day_cycles   (m_total_day_cycles),
        .m_total_night_cycles (m_total_night_cycles),
        .m_outage_total       (m_outage_total)
    );

    // samples waiting to be sent and results the supervisor still owes us
    sample_t pending_samples[$];
    result_t expected_results[$];
    sample_t held_sample;

    // predictor copy of the register file, kept in step with every apb write
    cfg_t cfg_shadow = '{
        morning_hour:       MORNING_HOUR_RST,
        morning_minute:     MORNING_MINUTE_RST,
        night_hour:         NIGHT_HOUR_RST,
        night_minute:       NIGHT_MINUTE_RST,
        battery_threshold:  BATTERY_THRESHOLD_RST,
        battery_hysteresis: BATTERY_HYSTERESIS_RST,
        force_cycle_limit:  FORCE_CYCLE_LIMIT_RST
    };

    // predictor copy of the supervisor state, values after reset
    logic [4:0]  seen_day = '0;
    logic        cycle_rearmed = 1'b1;
    logic        mains_rearmed = 1'b1;
    logic        force_reported = 1'b0;
    logic        forced_open = 1'b0;
    logic [15:0] day_cycles_today = '0;
    logic [15:0] night_cycles_today = '0;
    logic [31:0] day_cycles_total = '0;
    logic [31:0] night_cycles_total = '0;
    logic [31:0] mains_losses = '0;
    logic [15:0] cycles_off_mains = '0;

    // run bookkeeping
    int unsigned error_count = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 1;
    int unsigned force_engagements = 0;
    int unsigned mains_returns = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b0;
    bit          hurry = 1'b0;

    // random walk of the outside world: clock, gate cycle, mains and battery
    int w_day = 1;
    int w_hour = 6;
    int w_minute = 0;
    int w_batt = 2048;
    bit w_active = 1'b0;
    bit w_mains = 1'b1;

    // 10 ns clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop if the run hangs, far beyond the slowest legal run
    initial begin
        #20ms;
        $display("[gate_mains_cycle_supervisor] ERROR");
        $finish;
    end

    // one polled sample through the supervisor: day rollover, cycle count, mains, force
    task automatic predict_sample(input sample_t smp, output result_t res);
        logic        after_morning;
        logic        before_night;
        logic [12:0] release_level;
        res = '0;
        // a new calendar day restarts the daily counters
        if (smp.day_of_month != seen_day) begin
            seen_day = smp.day_of_month;
            day_cycles_today = '0;
            night_cycles_today = '0;
        end
        // rising edge of the cycle flag counts one cycle as day or night
        if (smp.cycle_active && cycle_rearmed) begin
            cycle_rearmed = 1'b0;
            after_morning = (smp.hour_now > cfg_shadow.morning_hour) ||
                            (smp.hour_now == cfg_shadow.morning_hour &&
                             smp.minute_now >= cfg_shadow.morning_minute);
            before_night = (smp.hour_now < cfg_shadow.night_hour) ||
                           (smp.hour_now == cfg_shadow.night_hour &&
                            smp.minute_now < cfg_shadow.night_minute);
            if (after_morning && before_night) begin
                day_cycles_today = day_cycles_today + 16'd1;
                day_cycles_total = day_cycles_total + 32'd1;
                res.day_cycle_counted = 1'b1;
            end else begin
                night_cycles_today = night_cycles_today + 16'd1;
                night_cycles_total = night_cycles_total + 32'd1;
                res.night_cycle_counted = 1'b1;
            end
            // cycle budget without mains sticks at its top value
            if (!smp.mains_present && cycles_off_mains != UNPOWERED_MAX) begin
                cycles_off_mains = cycles_off_mains + 16'd1;
            end
        end else if (!smp.cycle_active && !cycle_rearmed) begin
            cycle_rearmed = 1'b1;
        end
        // release point is formed one bit wider so it never wraps
        release_level = {1'b0, cfg_shadow.battery_threshold} +
                        {1'b0, cfg_shadow.battery_hysteresis};
        if (!smp.mains_present && mains_rearmed) begin
            // loss sample: battery and budget wait for the next sample
            mains_rearmed = 1'b0;
            mains_losses = mains_losses + 32'd1;
            res.outage_started = 1'b1;
        end else if (!smp.mains_present && !mains_rearmed) begin
            if (smp.battery_level < cfg_shadow.battery_threshold ||
                cycles_off_mains >= cfg_shadow.force_cycle_limit) begin
                forced_open = 1'b1;
            end else if ({1'b0, smp.battery_level} > release_level) begin
                forced_open = 1'b0;
            end
        end else if (smp.mains_present && !mains_rearmed) begin
            cycles_off_mains = '0;
            res.open_pulse = 1'b1;
            forced_open = 1'b0;
            mains_rearmed = 1'b1;
            mains_returns++;
        end
        // one notice per engagement of the forced opening
        if (forced_open && !force_reported) begin
            force_reported = 1'b1;
            res.force_started = 1'b1;
            force_engagements++;
        end else if (!forced_open && force_reported) begin
            force_reported = 1'b0;
        end
        res.force_open = forced_open;
        res.today_day_cycles = day_cycles_today;
        res.today_night_cycles = night_cycles_today;
        res.total_day_cycles = day_cycles_total;
        res.total_night_cycles = night_cycles_total;
        res.outage_total = mains_losses;
    endtask

    // idle lengths: mostly none or short, now and then long, none in quiet stretches or in a hurry
    function automatic int pick_gap(input bit quiet);
        int unsigned roll;
        if (quiet || hurry) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // sample driver: holds valid and payload until the transaction, then predicts it
    always @(posedge aclk) begin
        result_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_sample(held_sample, predicted);
                expected_results.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    held_sample = pending_samples.pop_front();
                    s_day_of_month  <= held_sample.day_of_month;
                    s_hour_now      <= held_sample.hour_now;
                    s_minute_now    <= held_sample.minute_now;
                    s_cycle_active  <= held_sample.cycle_active;
                    s_mains_present <= held_sample.mains_present;
                    s_battery_level <= held_sample.battery_level;
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 149) == 0) begin
                        send_quiet = !send_quiet;
                    end
                    send_gap = pick_gap(send_quiet);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // one field of a result against the prediction
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
        end
    endtask

    // result monitor: checks every transaction in order and stalls m_ready at random
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result transaction with no sample outstanding", $realtime);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    check_field("force_open", 32'(want.force_open), 32'(m_force_open));
                    check_field("open_pulse", 32'(want.open_pulse), 32'(m_open_pulse));
                    check_field("outage_started", 32'(want.outage_started),
                                32'(m_outage_started));
                    check_field("force_started", 32'(want.force_started),
                                32'(m_force_started));
                    check_field("day_cycle_counted", 32'(want.day_cycle_counted),
                                32'(m_day_cycle_counted));
                    check_field("night_cycle_counted", 32'(want.night_cycle_counted),
                                32'(m_night_cycle_counted));
                    check_field("today_day_cycles", 32'(want.today_day_cycles),
                                32'(m_today_day_cycles));
                    check_field("today_night_cycles", 32'(want.today_night_cycles),
                                32'(m_today_night_cycles));
                    check_field("total_day_cycles", want.total_day_cycles,
                                m_total_day_cycles);
                    check_field("total_night_cycles", want.total_night_cycles,
                                m_total_night_cycles);
                    check_field("outage_total", want.outage_total, m_outage_total);
                end
            end
            if (hurry) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 149) == 0) begin
                    recv_quiet = !recv_quiet;
                end
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap(recv_quiet);
                end
            end
        end
    end

    // apb write: setup cycle, access cycle, register lands on the edge with pready high
    // upper pwdata bits above the register width carry junk that must be dropped
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value,
                             input int unsigned width);
        logic [31:0] data;
        data = (width >= 32) ? value : (($urandom << width) | value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MORNING_HOUR:       cfg_shadow.morning_hour = data[4:0];
            REG_MORNING_MINUTE:     cfg_shadow.morning_minute = data[5:0];
            REG_NIGHT_HOUR:         cfg_shadow.night_hour = data[4:0];
            REG_NIGHT_MINUTE:       cfg_shadow.night_minute = data[5:0];
            REG_BATTERY_THRESHOLD:  cfg_shadow.battery_threshold = data[11:0];
            REG_BATTERY_HYSTERESIS: cfg_shadow.battery_hysteresis = data[11:0];
            REG_FORCE_CYCLE_LIMIT:  cfg_shadow.force_cycle_limit = data[15:0];
            default: ;
        endcase
    endtask

    // full register set, plus a write past the map that must change nothing
    task automatic set_config(input int unsigned mh, input int unsigned mm,
                              input int unsigned nh, input int unsigned nm,
                              input int unsigned th, input int unsigned hy,
                              input int unsigned lim);
        apb_write(REG_MORNING_HOUR, mh, 5);
        apb_write(REG_MORNING_MINUTE, mm, 6);
        apb_write(REG_NIGHT_HOUR, nh, 5);
        apb_write(REG_NIGHT_MINUTE, nm, 6);
        apb_write(REG_BATTERY_THRESHOLD, th, 12);
        apb_write(REG_BATTERY_HYSTERESIS, hy, 12);
        apb_write(REG_FORCE_CYCLE_LIMIT, lim, 16);
        apb_write(REG_UNUSED, $urandom, 32);
        settings_used++;
        // keep the battery walk near the new threshold so force toggles
        w_batt = th;
    endtask

    // wait until every sample is sent and every result is back, then settle
    task automatic drain;
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    function automatic sample_t mk_sample(input int unsigned day, input int unsigned hr,
                                          input int unsigned mn, input bit act,
                                          input bit mains, input int unsigned batt);
        sample_t smp;
        smp.day_of_month = 5'(day);
        smp.hour_now = 5'(hr);
        smp.minute_now = 6'(mn);
        smp.cycle_active = act;
        smp.mains_present = mains;
        smp.battery_level = 12'(batt);
        return smp;
    endfunction

    // mostly a plausible day of gate use, some fully random noise samples
    task automatic queue_walk(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 6) begin
                pending_samples.push_back(mk_sample($urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), $urandom_range(0, 4095)));
            end else begin
                // clock moves forward, rolling over hours and days
                w_minute += $urandom_range(0, 40);
                while (w_minute >= 60) begin
                    w_minute -= 60;
                    w_hour++;
                end
                if (w_hour >= 24) begin
                    w_hour = 0;
                    w_day = (w_day % 31) + 1;
                end
                if ($urandom_range(0, 49) == 0) begin
                    w_day = $urandom_range(1, 31);
                end
                // gate cycles start and end, mains drops out and comes back
                if ($urandom_range(0, 99) < 40) begin
                    w_active = !w_active;
                end
                if (w_mains ? ($urandom_range(0, 99) < 4) : ($urandom_range(0, 99) < 8)) begin
                    w_mains = !w_mains;
                end
                // battery drifts, with an occasional jump anywhere
                if ($urandom_range(0, 99) < 3) begin
                    w_batt = $urandom_range(0, 4095);
                end else begin
                    w_batt += int'($urandom_range(0, 200)) - 100;
                end
                if (w_batt < 0) begin
                    w_batt = 0;
                end else if (w_batt > 4095) begin
                    w_batt = 4095;
                end
                pending_samples.push_back(mk_sample(w_day, w_hour, w_minute, w_active,
                                                    w_mains, w_batt));
            end
        end
    endtask

    // an outage with gate cycles back to back that runs the budget past its limit
    task automatic queue_unpowered_run(input int unsigned cycles);
        pending_samples.push_back(mk_sample(15, 10, 0, 0, 1, 4095));
        pending_samples.push_back(mk_sample(15, 10, 0, 0, 0, 4095));
        repeat (cycles) begin
            pending_samples.push_back(mk_sample(15, 10, 0, 1, 0, 4095));
            pending_samples.push_back(mk_sample(15, 10, 0, 0, 0, 4095));
        end
        pending_samples.push_back(mk_sample(15, 10, 0, 0, 1, 4095));
    endtask

    // stimulus: reset, directed samples at reset settings, then phases of settings
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: day window 07:00 to 20:00, threshold 2048, margin 100, limit 10
        // day zero right after reset is no change of day
        pending_samples.push_back(mk_sample(0, 0, 0, 0, 1, 4095));
        // window edges: morning start is day, night start is night
        pending_samples.push_back(mk_sample(1, 7, 0, 1, 1, 3000));
        pending_samples.push_back(mk_sample(1, 7, 1, 0, 1, 3000));
        pending_samples.push_back(mk_sample(1, 19, 59, 1, 1, 3000));
        pending_samples.push_back(mk_sample(1, 20, 0, 0, 1, 3000));
        pending_samples.push_back(mk_sample(1, 20, 0, 1, 1, 3000));
        pending_samples.push_back(mk_sample(1, 6, 59, 0, 1, 3000));
        pending_samples.push_back(mk_sample(1, 6, 59, 1, 1, 3000));
        // loss sample with a flat battery must not force yet, the next one does
        pending_samples.push_back(mk_sample(31, 31, 63, 0, 0, 0));
        pending_samples.push_back(mk_sample(31, 31, 63, 0, 0, 0));
        // hysteresis: exactly at threshold plus margin holds, one above releases
        pending_samples.push_back(mk_sample(31, 12, 0, 0, 0, 2148));
        pending_samples.push_back(mk_sample(31, 12, 0, 0, 0, 2149));
        pending_samples.push_back(mk_sample(31, 12, 0, 0, 0, 2047));
        // a cycle made on battery, then mains returns with an open pulse
        pending_samples.push_back(mk_sample(31, 12, 0, 1, 0, 2047));
        pending_samples.push_back(mk_sample(31, 12, 0, 0, 1, 2047));
        pending_samples.push_back(mk_sample(31, 12, 0, 0, 1, 0));
        // new day and a cycle in the same sample, out of range clock counts as night
        pending_samples.push_back(mk_sample(2, 24, 60, 1, 1, 4095));
        pending_samples.push_back(mk_sample(2, 24, 60, 1, 1, 4095));
        // outage with a healthy battery and an unspent budget stays unforced
        pending_samples.push_back(mk_sample(16, 0, 0, 0, 0, 4095));
        pending_samples.push_back(mk_sample(16, 0, 0, 0, 0, 4095));
        pending_samples.push_back(mk_sample(16, 0, 0, 0, 1, 4095));
        drain();

        // extremes: day window 00:00 to 23:59, zero threshold and margin, zero budget
        set_config(0, 0, 23, 59, 0, 0, 0);
        queue_walk(250);
        drain();

        // night start before morning start: every cycle is night, widest margin
        set_config(23, 59, 0, 0, 4095, 4095, 65535);
        queue_walk(250);
        drain();

        // empty day window, small budget
        set_config(12, 30, 12, 30, 2048, 200, 3);
        queue_walk(250);
        drain();

        // assorted settings, hours sometimes past 23 as the register width allows
        repeat (4) begin
            set_config($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 31),
                       $urandom_range(0, 63), $urandom_range(300, 3800),
                       $urandom_range(0, 400), $urandom_range(0, 8));
            queue_walk(220);
            drain();
        end

        // back to the reset values
        set_config(32'(MORNING_HOUR_RST), 32'(MORNING_MINUTE_RST), 32'(NIGHT_HOUR_RST),
                   32'(NIGHT_MINUTE_RST), 32'(BATTERY_THRESHOLD_RST),
                   32'(BATTERY_HYSTERESIS_RST), 32'(FORCE_CYCLE_LIMIT_RST));
        queue_walk(180);
        drain();

        // cycle budget alone engages the force once it reaches the limit, and it holds
        // until mains returns; both sides run without idling here
        set_config(32'(MORNING_HOUR_RST), 32'(MORNING_MINUTE_RST), 32'(NIGHT_HOUR_RST),
                   32'(NIGHT_MINUTE_RST), 100, 0, 8);
        hurry = 1'b1;
        queue_unpowered_run(12);
        drain();
        hurry = 1'b0;

        // trailing margin so a stray extra result still gets caught
        repeat (10) @(posedge aclk);

        $display("checked %0d results under %0d register settings", results_checked,
                 settings_used);
        $display("day/night cycles %0d/%0d, outages %0d, returns %0d, forced openings %0d",
                 day_cycles_total, night_cycles_total, mains_losses, mains_returns,
                 force_engagements);
        if (error_count == 0) begin
            $display("[gate_mains_cycle_supervisor] OK");
        end else begin
            $display("[gate_mains_cycle_supervisor] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
